// ===== rtl/lnig_pkg.sv =====
// Shared constants, types and helper function of the lattice neighbour index generator.
package lnig_pkg;

    localparam int LEN_W       = 17;
    localparam int KB_W        = 5;
    localparam int AXIS_W      = 2;
    localparam int DIV_STEPS   = 4;
    localparam int LEN_REGS    = 4;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REG_DIM_COUNT = 3'd0;
    localparam logic [2:0] REG_LENGTH_A  = 3'd1;
    localparam logic [2:0] REG_LENGTH_B  = 3'd2;
    localparam logic [2:0] REG_LENGTH_C  = 3'd3;
    localparam logic [2:0] REG_LENGTH_D  = 3'd4;
    localparam logic [2:0] REG_EDGE_MODE = 3'd5;

    localparam logic [2:0]       DIM_COUNT_RST = 3'd2;
    localparam logic [LEN_W-1:0] LENGTH_A_RST  = 17'd16;
    localparam logic [LEN_W-1:0] LENGTH_B_RST  = 17'd16;
    localparam logic [LEN_W-1:0] LENGTH_C_RST  = 17'd1;
    localparam logic [LEN_W-1:0] LENGTH_D_RST  = 17'd1;
    localparam logic             EDGE_MODE_RST = 1'b0;

    typedef struct packed {
        logic busy;
        logic bad_all;
        logic edge_mode;
    } t_cfg_ctl;

    // Smallest k with 2**k >= len: number of coordinate bits of this extent.
    function automatic logic [KB_W-1:0] len_bits(input logic [LEN_W-1:0] len);
        logic [KB_W-1:0] k;
        k = '0;
        for (int i = 0; i < LEN_W; i++) begin
            if (len > (LEN_W'(1) << i)) begin
                k = KB_W'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/lnig_if.sv =====
// Valid/ready channel interfaces for site items and neighbour items.
interface lnig_site_if #(parameter int SITE_BITS = 16) ();
    logic                 valid;
    logic                 ready;
    logic [SITE_BITS-1:0] site;

    modport source (output valid, output site, input ready);
    modport sink   (input valid, input site, output ready);
endinterface

interface lnig_nb_if #(parameter int SITE_BITS = 16) ();
    logic               valid;
    logic               ready;
    logic [SITE_BITS:0] neighbour;
    logic [1:0]         axis;
    logic               backward;
    logic               ghost;
    logic               bad_site;
    logic               last;

    modport source (output valid, output neighbour, output axis, output backward,
                    output ghost, output bad_site, output last, input ready);
    modport sink   (input valid, input neighbour, input axis, input backward,
                    input ghost, input bad_site, input last, output ready);
endinterface

// ===== rtl/lattice_neighbour_index_gen_top.sv =====
// Top level of the lattice neighbour index generator.
//
//   channel   dir  handshake          payload
//   i_site    in   valid/ready        site
//   o_nb      out  valid/ready        neighbour, axis, backward, ghost, bad_site, last
//   apb       in   psel/penable/pready dim_count, length_a..d, edge_mode
//
// A good site gives 2*dims items, one a cycle while o_nb is not stalled; a bad site gives one item.
// The front end resolves four coordinate bits a cycle, dimension by dimension, ahead
// of a two-entry queue. After reset and after each register write the stride
// sequencer steps through its multiply and accumulate states per dimension,
// stopping early on overflow or a zero length, and holds i_site.ready low meanwhile.
// A stalled o_nb holds the output register and the back end waits behind it.
module lattice_neighbour_index_gen_top import lnig_pkg::*; #(
    parameter int MAX_DIMS  = 4,
    parameter int SITE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lnig_site_if.sink            i_site,
    lnig_nb_if.source            o_nb,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int NDIM = (MAX_DIMS < LEN_REGS) ? MAX_DIMS : LEN_REGS;
    localparam int NB   = SITE_BITS + 1;
    localparam int DW   = (NDIM > 1) ? $clog2(NDIM) : 1;
    localparam int EW   = SITE_BITS + 1 + 2 * NDIM + NDIM * NB;

    t_cfg_ctl                    ctl;
    logic [DW-1:0]               dims_m1;
    logic [NB-1:0]               total;
    logic [NDIM-1:0][NB-1:0]     stride;
    logic [NDIM-1:0][NB-1:0]     span;
    logic [NDIM-1:0][NB-1:0]     sstart;
    logic [NDIM-1:0][KB_W-1:0]   kbits;
    logic [NDIM-1:0][LEN_W-1:0]  lenm1;

    logic                        f_push;
    logic [SITE_BITS-1:0]        f_site;
    logic                        f_bad;
    logic [NDIM-1:0]             f_fedge;
    logic [NDIM-1:0]             f_bedge;
    logic [NDIM-1:0][NB-1:0]     f_wrapf;

    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic [EW-1:0]               q_din;
    logic [EW-1:0]               q_dout;

    logic [SITE_BITS-1:0]        b_site;
    logic                        b_bad;
    logic [NDIM-1:0]             b_fedge;
    logic [NDIM-1:0]             b_bedge;
    logic [NDIM-1:0][NB-1:0]     b_wrapf;

    lnig_cfg #(.NDIM(NDIM), .SITE_BITS(SITE_BITS)) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_ctl     (ctl),
        .o_dims_m1 (dims_m1),
        .o_total   (total),
        .o_stride  (stride),
        .o_span    (span),
        .o_sstart  (sstart),
        .o_kbits   (kbits),
        .o_lenm1   (lenm1)
    );

    lnig_front #(.NDIM(NDIM), .SITE_BITS(SITE_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_site.valid),
        .o_ready   (i_site.ready),
        .i_site    (i_site.site),
        .i_ctl     (ctl),
        .i_dims_m1 (dims_m1),
        .i_total   (total),
        .i_sstart  (sstart),
        .i_kbits   (kbits),
        .i_lenm1   (lenm1),
        .i_full    (q_full),
        .o_push    (f_push),
        .o_site    (f_site),
        .o_bad     (f_bad),
        .o_fedge   (f_fedge),
        .o_bedge   (f_bedge),
        .o_wrapf   (f_wrapf)
    );

    assign q_din = {f_site, f_bad, f_fedge, f_bedge, f_wrapf};

    lnig_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_dout)
    );

    assign {b_site, b_bad, b_fedge, b_bedge, b_wrapf} = q_dout;

    lnig_back #(.NDIM(NDIM), .SITE_BITS(SITE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_site      (b_site),
        .i_bad       (b_bad),
        .i_fedge     (b_fedge),
        .i_bedge     (b_bedge),
        .i_wrapf     (b_wrapf),
        .i_ctl       (ctl),
        .i_dims_m1   (dims_m1),
        .i_total     (total),
        .i_stride    (stride),
        .i_span      (span),
        .o_valid     (o_nb.valid),
        .i_ready     (o_nb.ready),
        .o_neighbour (o_nb.neighbour),
        .o_axis      (o_nb.axis),
        .o_backward  (o_nb.backward),
        .o_ghost     (o_nb.ghost),
        .o_bad_site  (o_nb.bad_site),
        .o_last      (o_nb.last)
    );

endmodule

// ===== rtl/lnig_cfg.sv =====
// Register file with APB access and the sequencer that derives strides and totals.
module lnig_cfg import lnig_pkg::*; #(
    parameter int NDIM      = 4,
    parameter int SITE_BITS = 16,
    localparam int NB       = SITE_BITS + 1,
    localparam int DW       = (NDIM > 1) ? $clog2(NDIM) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready,
    output t_cfg_ctl                      o_ctl,
    output logic [DW-1:0]                 o_dims_m1,
    output logic [NB-1:0]                 o_total,
    output logic [NDIM-1:0][NB-1:0]       o_stride,
    output logic [NDIM-1:0][NB-1:0]       o_span,
    output logic [NDIM-1:0][NB-1:0]       o_sstart,
    output logic [NDIM-1:0][KB_W-1:0]     o_kbits,
    output logic [NDIM-1:0][LEN_W-1:0]    o_lenm1
);

    localparam int             PW    = NB + LEN_W;
    localparam logic [PW-1:0]  LIMIT = PW'(1) << SITE_BITS;

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_MUL  = 3'b010,
        CS_ACC  = 3'b100
    } t_cfg_state;

    logic [2:0]       r_dim_count;
    logic [LEN_W-1:0] r_len_a, r_len_b, r_len_c, r_len_d;
    logic             r_edge_mode;

    t_cfg_state               r_st;
    logic [DW-1:0]            r_idx;
    logic [NB-1:0]            r_tot;
    logic [PW-1:0]            r_prod;
    logic                     r_bad_all;
    logic [NB-1:0]            r_total;
    logic [NDIM-1:0][NB-1:0]  r_stride;
    logic [NDIM-1:0][NB-1:0]  r_span;
    logic [NDIM-1:0][NB-1:0]  r_sstart;
    logic [NDIM-1:0][KB_W-1:0] r_kbits;
    logic [NDIM-1:0][LEN_W-1:0] r_lenm1;

    logic                              wr_en;
    logic [2:0]                        wr_idx;
    logic [LEN_REGS-1:0][LEN_W-1:0]    len_vec;
    logic [LEN_W-1:0]                  c_len;
    logic [KB_W-1:0]                   c_kbits;
    logic                              c_big;
    logic [DW-1:0]                     dims_m1;

    assign wr_en   = psel & penable & pwrite;
    assign wr_idx  = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign len_vec = {r_len_d, r_len_c, r_len_b, r_len_a};
    assign c_len   = len_vec[r_idx];
    assign c_kbits = len_bits(c_len);
    assign c_big   = (r_prod > LIMIT) || (r_prod == '0);

    always_comb begin
        if (r_dim_count == '0) begin
            dims_m1 = '0;
        end else if (int'(r_dim_count) > NDIM) begin
            dims_m1 = DW'(NDIM - 1);
        end else begin
            dims_m1 = DW'(r_dim_count - 3'd1);
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_DIM_COUNT: prdata = PDATA_W'(r_dim_count);
            REG_LENGTH_A:  prdata = PDATA_W'(r_len_a);
            REG_LENGTH_B:  prdata = PDATA_W'(r_len_b);
            REG_LENGTH_C:  prdata = PDATA_W'(r_len_c);
            REG_LENGTH_D:  prdata = PDATA_W'(r_len_d);
            REG_EDGE_MODE: prdata = PDATA_W'(r_edge_mode);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DIM_COUNT_RST;
            r_len_a     <= LENGTH_A_RST;
            r_len_b     <= LENGTH_B_RST;
            r_len_c     <= LENGTH_C_RST;
            r_len_d     <= LENGTH_D_RST;
            r_edge_mode <= EDGE_MODE_RST;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_DIM_COUNT: r_dim_count <= pwdata[2:0];
                REG_LENGTH_A:  r_len_a     <= pwdata[LEN_W-1:0];
                REG_LENGTH_B:  r_len_b     <= pwdata[LEN_W-1:0];
                REG_LENGTH_C:  r_len_c     <= pwdata[LEN_W-1:0];
                REG_LENGTH_D:  r_len_d     <= pwdata[LEN_W-1:0];
                REG_EDGE_MODE: r_edge_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Recompute derived values after reset and after every write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= CS_MUL;
            r_idx     <= '0;
            r_tot     <= NB'(1);
            r_bad_all <= 1'b0;
        end else if (wr_en) begin
            r_st      <= CS_MUL;
            r_idx     <= '0;
            r_tot     <= NB'(1);
            r_bad_all <= 1'b0;
        end else begin
            unique case (r_st)
                CS_IDLE: ;
                CS_MUL: begin
                    r_prod <= PW'(r_tot) * PW'(c_len);
                    r_st   <= CS_ACC;
                end
                CS_ACC: begin
                    r_stride[r_idx] <= r_tot;
                    r_span[r_idx]   <= NB'(r_prod - PW'(r_tot));
                    r_kbits[r_idx]  <= c_kbits;
                    r_sstart[r_idx] <= (c_kbits == '0) ? '0
                                     : NB'(PW'(r_tot) << (c_kbits - KB_W'(1)));
                    r_lenm1[r_idx]  <= c_len - LEN_W'(1);
                    r_total         <= NB'(r_prod);
                    r_tot           <= NB'(r_prod);
                    if (c_big || r_idx == dims_m1) begin
                        r_bad_all <= c_big;
                        r_st      <= CS_IDLE;
                    end else begin
                        r_idx <= r_idx + DW'(1);
                        r_st  <= CS_MUL;
                    end
                end
                default: r_st <= CS_IDLE;
            endcase
        end
    end

    assign o_ctl.busy      = (r_st != CS_IDLE) || wr_en;
    assign o_ctl.bad_all   = r_bad_all;
    assign o_ctl.edge_mode = r_edge_mode;
    assign o_dims_m1       = dims_m1;
    assign o_total         = r_total;
    assign o_stride        = r_stride;
    assign o_span          = r_span;
    assign o_sstart        = r_sstart;
    assign o_kbits         = r_kbits;
    assign o_lenm1         = r_lenm1;

endmodule

// ===== rtl/lnig_front.sv =====
// Front end: accepts sites, flags bad ones and splits good ones into coordinates.
module lnig_front import lnig_pkg::*; #(
    parameter int NDIM      = 4,
    parameter int SITE_BITS = 16,
    localparam int NB       = SITE_BITS + 1,
    localparam int DW       = (NDIM > 1) ? $clog2(NDIM) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [SITE_BITS-1:0]        i_site,
    input  t_cfg_ctl                    i_ctl,
    input  logic [DW-1:0]               i_dims_m1,
    input  logic [NB-1:0]               i_total,
    input  logic [NDIM-1:0][NB-1:0]     i_sstart,
    input  logic [NDIM-1:0][KB_W-1:0]   i_kbits,
    input  logic [NDIM-1:0][LEN_W-1:0]  i_lenm1,
    input  logic                        i_full,
    output logic                        o_push,
    output logic [SITE_BITS-1:0]        o_site,
    output logic                        o_bad,
    output logic [NDIM-1:0]             o_fedge,
    output logic [NDIM-1:0]             o_bedge,
    output logic [NDIM-1:0][NB-1:0]     o_wrapf
);

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_DIV  = 3'b010,
        FS_PUSH = 3'b100
    } t_front_state;

    t_front_state             r_st;
    logic [SITE_BITS-1:0]     r_site;
    logic                     r_bad;
    logic [DW-1:0]            r_dim;
    logic [KB_W-1:0]          r_bits;
    logic [SITE_BITS-1:0]     r_rem;
    logic [SITE_BITS-1:0]     r_rin;
    logic [NB-1:0]            r_ss;
    logic [LEN_W-1:0]         r_q;
    logic [NDIM-1:0]          r_fedge;
    logic [NDIM-1:0]          r_bedge;
    logic [NDIM-1:0][NB-1:0]  r_wrapf;

    logic                     acc;
    logic                     c_bad;
    logic                     dim_last;
    logic [DW-1:0]            c_nd;
    logic [SITE_BITS-1:0]     c_rem;
    logic [NB-1:0]            c_ss;
    logic [LEN_W-1:0]         c_q;

    assign o_push   = (r_st == FS_PUSH) && !i_full;
    assign o_ready  = !i_ctl.busy && ((r_st == FS_IDLE) || o_push);
    assign acc      = i_valid && o_ready;
    assign c_bad    = i_ctl.bad_all || (NB'(i_site) >= i_total);
    assign dim_last = r_bits <= KB_W'(DIV_STEPS);
    assign c_nd     = acc ? i_dims_m1 : r_dim - DW'(1);

    // Restoring division, several quotient bits a cycle.
    always_comb begin
        c_rem = r_rem;
        c_ss  = r_ss;
        c_q   = r_q;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (KB_W'(j) < r_bits) begin
                if (NB'(c_rem) >= c_ss) begin
                    c_rem = c_rem - SITE_BITS'(c_ss);
                    c_q   = {c_q[LEN_W-2:0], 1'b1};
                end else begin
                    c_q   = {c_q[LEN_W-2:0], 1'b0};
                end
                c_ss = c_ss >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FS_IDLE;
        end else if (acc) begin
            r_site <= i_site;
            r_bad  <= c_bad;
            r_st   <= c_bad ? FS_PUSH : FS_DIV;
            r_dim  <= i_dims_m1;
            r_bits <= i_kbits[c_nd];
            r_ss   <= i_sstart[c_nd];
            r_rem  <= i_site;
            r_rin  <= i_site;
            r_q    <= '0;
        end else if (o_push) begin
            r_st <= FS_IDLE;
        end else if (r_st == FS_DIV) begin
            if (dim_last) begin
                r_fedge[r_dim] <= (c_q == i_lenm1[r_dim]);
                r_bedge[r_dim] <= (c_q == '0);
                r_wrapf[r_dim] <= NB'(r_site) - NB'(r_rin) + NB'(c_rem);
                r_rem          <= c_rem;
                r_rin          <= c_rem;
                r_q            <= '0;
                if (r_dim == '0) begin
                    r_st <= FS_PUSH;
                end else begin
                    r_dim  <= r_dim - DW'(1);
                    r_bits <= i_kbits[c_nd];
                    r_ss   <= i_sstart[c_nd];
                end
            end else begin
                r_rem  <= c_rem;
                r_ss   <= c_ss;
                r_q    <= c_q;
                r_bits <= r_bits - KB_W'(DIV_STEPS);
            end
        end
    end

    assign o_site  = r_site;
    assign o_bad   = r_bad;
    assign o_fedge = r_fedge;
    assign o_bedge = r_bedge;
    assign o_wrapf = r_wrapf;

endmodule

// ===== rtl/lnig_queue.sv =====
// Small register queue between the front end and the back end.
module lnig_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/lnig_back.sv =====
// Back end: walks a queued site's dimensions, one neighbour item a cycle unless stalled.
module lnig_back import lnig_pkg::*; #(
    parameter int NDIM      = 4,
    parameter int SITE_BITS = 16,
    localparam int NB       = SITE_BITS + 1,
    localparam int DW       = (NDIM > 1) ? $clog2(NDIM) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_pop,
    input  logic [SITE_BITS-1:0]        i_site,
    input  logic                        i_bad,
    input  logic [NDIM-1:0]             i_fedge,
    input  logic [NDIM-1:0]             i_bedge,
    input  logic [NDIM-1:0][NB-1:0]     i_wrapf,
    input  t_cfg_ctl                    i_ctl,
    input  logic [DW-1:0]               i_dims_m1,
    input  logic [NB-1:0]               i_total,
    input  logic [NDIM-1:0][NB-1:0]     i_stride,
    input  logic [NDIM-1:0][NB-1:0]     i_span,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [NB-1:0]               o_neighbour,
    output logic [AXIS_W-1:0]           o_axis,
    output logic                        o_backward,
    output logic                        o_ghost,
    output logic                        o_bad_site,
    output logic                        o_last
);

    logic                     r_cur_v;
    logic [SITE_BITS-1:0]     r_site;
    logic                     r_bad;
    logic [NDIM-1:0]          r_fedge;
    logic [NDIM-1:0]          r_bedge;
    logic [NDIM-1:0][NB-1:0]  r_wrapf;
    logic [DW-1:0]            r_dim;
    logic                     r_dir;

    logic                     r_ov;
    logic [NB-1:0]            r_nb;
    logic [AXIS_W-1:0]        r_axis;
    logic                     r_bwd;
    logic                     r_ghost;
    logic                     r_bad_o;
    logic                     r_last;

    logic                     adv;
    logic                     fin;
    logic                     c_last;
    logic                     c_edge;
    logic [NB-1:0]            c_nb;
    logic                     c_ghost;
    logic [NB-1:0]            c_str;
    logic [NB-1:0]            c_site;

    assign adv    = r_cur_v && (!r_ov || i_ready);
    assign c_last = r_bad || ((r_dim == i_dims_m1) && r_dir);
    assign fin    = adv && c_last;
    assign o_pop  = i_valid && (!r_cur_v || fin);
    assign c_edge = r_dir ? r_bedge[r_dim] : r_fedge[r_dim];
    assign c_str  = i_stride[r_dim];
    assign c_site = NB'(r_site);

    always_comb begin
        c_ghost = 1'b0;
        if (r_bad) begin
            c_nb = '0;
        end else if (c_edge && i_ctl.edge_mode) begin
            c_nb    = i_total;
            c_ghost = 1'b1;
        end else if (c_edge) begin
            c_nb = r_dir ? c_site + i_span[r_dim] : r_wrapf[r_dim];
        end else begin
            c_nb = r_dir ? c_site - c_str : c_site + c_str;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
        end else if (o_pop) begin
            r_cur_v <= 1'b1;
            r_site  <= i_site;
            r_bad   <= i_bad;
            r_fedge <= i_fedge;
            r_bedge <= i_bedge;
            r_wrapf <= i_wrapf;
            r_dim   <= '0;
            r_dir   <= 1'b0;
        end else if (fin) begin
            r_cur_v <= 1'b0;
        end else if (adv) begin
            if (r_dir) begin
                r_dim <= r_dim + DW'(1);
                r_dir <= 1'b0;
            end else begin
                r_dir <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov    <= 1'b1;
            r_nb    <= c_nb;
            r_axis  <= r_bad ? '0 : AXIS_W'(r_dim);
            r_bwd   <= r_dir && !r_bad;
            r_ghost <= c_ghost;
            r_bad_o <= r_bad;
            r_last  <= c_last;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid     = r_ov;
    assign o_neighbour = r_nb;
    assign o_axis      = r_axis;
    assign o_backward  = r_bwd;
    assign o_ghost     = r_ghost;
    assign o_bad_site  = r_bad_o;
    assign o_last      = r_last;

endmodule

// ===== rtl/lnig_checker.sv =====
// Port-level checker of the neighbour output channel, bound to the top level.
module lnig_checker #(
    parameter int SITE_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [SITE_BITS:0] i_neighbour,
    input logic [1:0]         i_axis,
    input logic               i_backward,
    input logic               i_ghost,
    input logic               i_bad_site,
    input logic               i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_neighbour) && $stable(i_axis)
            && $stable(i_backward) && $stable(i_ghost) && $stable(i_bad_site)
            && $stable(i_last))
        else $error("stalled item changed");

    a_bad_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_bad_site |-> i_last && (i_neighbour == '0) && !i_ghost
            && !i_backward && (i_axis == 2'd0))
        else $error("bad site item malformed");

    a_fwd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_bad_site && !i_backward |-> !i_last)
        else $error("forward item flagged last");

    a_ghost_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ghost |-> !i_bad_site)
        else $error("ghost on bad site item");

endmodule

bind lattice_neighbour_index_gen_top lnig_checker #(.SITE_BITS(SITE_BITS)) u_lnig_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_nb.valid),
    .i_ready     (o_nb.ready),
    .i_neighbour (o_nb.neighbour),
    .i_axis      (o_nb.axis),
    .i_backward  (o_nb.backward),
    .i_ghost     (o_nb.ghost),
    .i_bad_site  (o_nb.bad_site),
    .i_last      (o_nb.last)
);
